// ===== design/assert_macros.svh =====
// Assertion macros used by dag_shortest_path.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge, held off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property that must also hold during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== design/dsp_pkg.sv =====
// Shared constants and opcodes for the DAG shortest-path block.
// No dependencies.
package dsp_pkg;

    localparam int NODE_COUNT_DEF = 16;
    localparam int NODE_W         = 4;
    localparam int WEIGHT_W       = 16;
    localparam int DIST_W         = 20;
    localparam int unsigned DIST_MAX = 32'd1048575;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

// ===== design/dsp_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the edge table and the per-node cost store. No dependencies.
module dsp_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/dag_shortest_path.sv =====
// DAG shortest path, single source at node 0. After reset the edge table is
// swept to zero, one entry a cycle; no item is taken meanwhile. A load item
// writes its weight into the edge table as it is taken, if both nodes are in
// range. A query rebuilds the cost to the destination for every node, highest
// index first, reading one edge and one cost per cycle from the two memories.
// A node below the destination scans its successors in S_BUILD and then
// stores its cost in S_BWRITE; the destination and the nodes past it go
// straight there. The route walk then emits each node in S_EMIT and scans
// its successors in S_SEARCH for the next hop, holding in S_EMIT while the
// result side stalls.
// Depends on dsp_pkg, dsp_ram and assert_macros.svh.
`include "assert_macros.svh"

module dag_shortest_path #(
    parameter int NODE_COUNT = dsp_pkg::NODE_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // from_node[3:0], to_node[7:4], weight[23:8], destination[27:24], zero pad
    input  logic [dsp_pkg::S_DATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [0:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // distance[19:0], route_node[23:20]
    output logic [dsp_pkg::M_DATA_W-1:0] m_tdata,
    // found[0]
    output logic [0:0]                   m_tuser,
    output logic                         m_tlast
);

    import dsp_pkg::*;

    localparam int NW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int EDGE_DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int AW   = $clog2(EDGE_DEPTH);
    localparam int DW   = WEIGHT_W + NW;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_BUILD  = 7'b0000100,
        S_BWRITE = 7'b0001000,
        S_EMIT   = 7'b0010000,
        S_SEARCH = 7'b0100000,
        S_NOTF   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]   clr_reg, clr_next;
    logic [NW-1:0]   row_reg, row_next;
    logic [NW-1:0]   dst_reg, dst_next;
    logic [NW:0]     n_reg, n_next;
    logic            pend_reg, pend_next;
    logic            best_reach_reg, best_reach_next;
    logic [DW-1:0]   best_reg, best_next;
    logic [DW-1:0]   total_reg, total_next;
    logic            force_reg, force_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg, out_found_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic [NODE_W-1:0] out_node_reg, out_node_next;
    logic            out_last_reg, out_last_next;

    // Input fields
    logic [NODE_W-1:0]   in_from, in_to, in_dst;
    logic [WEIGHT_W-1:0] in_weight;
    logic [NODE_W+NW-1:0] from_ext, to_ext, dst_ext;
    assign in_from   = s_tdata[3:0];
    assign in_to     = s_tdata[7:4];
    assign in_weight = s_tdata[23:8];
    assign in_dst    = s_tdata[27:24];
    assign from_ext  = {{NW{1'b0}}, in_from};
    assign to_ext    = {{NW{1'b0}}, in_to};
    assign dst_ext   = {{NW{1'b0}}, in_dst};

    // Memory ports
    logic            e_we;
    logic [AW-1:0]   e_waddr, e_raddr;
    logic [WEIGHT_W-1:0] e_wdata, e_rdata;
    logic            c_we;
    logic [DW:0]     c_wdata, c_rdata;
    logic [NW-1:0]   n_idx;

    assign n_idx   = n_reg[NW-1:0];
    assign e_raddr = AW'(32'(row_reg) * NODE_COUNT + 32'(n_idx));

    dsp_ram #(.DEPTH(EDGE_DEPTH), .WIDTH(WEIGHT_W), .ADDR_W(AW)) u_edge (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    dsp_ram #(.DEPTH(NODE_COUNT), .WIDTH(DW + 1), .ADDR_W(NW)) u_cost (
        .aclk(aclk), .we(c_we), .waddr(row_reg), .wdata(c_wdata),
        .raddr(n_idx), .rdata(c_rdata)
    );

    assign c_we    = (state_reg == S_BWRITE);
    assign c_wdata = {best_reach_reg, best_reg};

    // Returned edge and cost for the scan
    logic            rd_reach, edge_ok;
    logic [DW-1:0]   rd_dist;
    logic [DW:0]     cand;
    assign rd_reach = c_rdata[DW];
    assign rd_dist  = c_rdata[DW-1:0];
    assign edge_ok  = (e_rdata != '0) && rd_reach;
    assign cand     = (DW + 1)'(e_rdata) + {1'b0, rd_dist};

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Next node to build and how it starts
    logic          nv_go;
    logic [NW-1:0] nv;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        row_next        = row_reg;
        dst_next        = dst_reg;
        n_next          = n_reg;
        pend_next       = 1'b0;
        best_reach_next = best_reach_reg;
        best_next       = best_reg;
        total_next      = total_reg;
        force_next      = force_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_dist_next   = out_dist_reg;
        out_node_next   = out_node_reg;
        out_last_next   = out_last_reg;
        e_we            = 1'b0;
        e_waddr         = AW'(32'(from_ext[NW-1:0]) * NODE_COUNT + 32'(to_ext[NW-1:0]));
        e_wdata         = in_weight;
        nv_go           = 1'b0;
        nv              = row_reg;

        case (state_reg)
            // Sweep the edge table to zero
            S_CLEAR: begin
                e_we    = 1'b1;
                e_waddr = clr_reg;
                e_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == EDGE_DEPTH - 1) begin
                    state_next = S_IDLE;
                end
            end
            // Take load and query items
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == OP_LOAD) begin
                        e_we = (32'(in_from) < NODE_COUNT) && (32'(in_to) < NODE_COUNT);
                    end else if (32'(in_dst) >= NODE_COUNT) begin
                        state_next = S_NOTF;
                    end else begin
                        dst_next = dst_ext[NW-1:0];
                        nv_go    = 1'b1;
                        nv       = NW'(NODE_COUNT - 1);
                    end
                end
            end
            // Relax successors of the current node, one per cycle
            S_BUILD: begin
                if (n_reg < (NW + 1)'(NODE_COUNT)) begin
                    n_next    = n_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && edge_ok &&
                    (!best_reach_reg || cand < {1'b0, best_reg})) begin
                    best_reach_next = 1'b1;
                    best_next       = DW'(cand);
                end
                if (n_reg == (NW + 1)'(NODE_COUNT) && !pend_reg) begin
                    state_next = S_BWRITE;
                end
            end
            // Store the node cost, then step down, start the walk or report no route
            S_BWRITE: begin
                if (row_reg != '0) begin
                    nv_go = 1'b1;
                    nv    = row_reg - 1'b1;
                end else if (best_reach_reg) begin
                    total_next = best_reg;
                    force_next = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_NOTF;
                end
            end
            // Emit the current route node
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_dist_next  = (32'(total_reg) > DIST_MAX) ?
                                     DIST_W'(DIST_MAX) : DIST_W'(total_reg);
                    out_node_next  = NODE_W'(row_reg);
                    out_last_next  = (row_reg == dst_reg) || force_reg;
                    if ((row_reg == dst_reg) || force_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        n_next     = (NW + 1)'(row_reg) + 1'b1;
                        state_next = S_SEARCH;
                    end
                end
            end
            // Find the first successor on a minimal route, or end the walk if none is found
            S_SEARCH: begin
                if (pend_reg && edge_ok && cand == {1'b0, best_reg}) begin
                    row_next   = NW'(n_reg - 1'b1);
                    best_next  = rd_dist;
                    state_next = S_EMIT;
                end else begin
                    if (n_reg < (NW + 1)'(NODE_COUNT)) begin
                        n_next    = n_reg + 1'b1;
                        pend_next = 1'b1;
                    end else if (!pend_reg) begin
                        force_next = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            // Report no route
            S_NOTF: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_dist_next  = '0;
                    out_node_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase

        // Start building a node: destination and nodes past it need no scan
        if (nv_go) begin
            row_next = nv;
            if (nv >= dst_next) begin
                best_reach_next = (nv == dst_next);
                best_next       = '0;
                state_next      = S_BWRITE;
            end else begin
                best_reach_next = 1'b0;
                best_next       = '0;
                n_next          = (NW + 1)'(nv) + 1'b1;
                state_next      = S_BUILD;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        row_reg        <= row_next;
        dst_reg        <= dst_next;
        n_reg          <= n_next;
        best_reach_reg <= best_reach_next;
        best_reg       <= best_next;
        total_reg      <= total_next;
        force_reg      <= force_next;
        out_found_reg  <= out_found_next;
        out_dist_reg   <= out_dist_next;
        out_node_reg   <= out_node_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_node_reg, out_dist_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `ASSERT_CLK(a_no_take_in_clear, (state_reg == S_CLEAR) |-> !s_tready, "item taken during clear")
    `ASSERT_CLK(a_notfound_last, (m_tvalid && !m_tuser[0]) |-> m_tlast, "no-route result not last")
    `ASSERT_CLK(a_write_drained, (state_reg == S_BWRITE) |-> !pend_reg, "cost write with read pending")
    `ASSERT_CLK(a_notfound_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "no-route result not zero")

endmodule
